>>> rtl/core/adsr_pkg.sv
// ---------------------------------------------------------------------------
// ADSR envelope shaper package
// Shared widths, register indexes, phase codes, reset values and the job
// record that travels from the classifier to the divider back end.
// ---------------------------------------------------------------------------
package adsr_pkg;

  localparam int COUNT_WIDTH  = 24;
  localparam int SAMPLE_WIDTH = 16;
  localparam int LEVEL_WIDTH  = 16;
  localparam int ENV_WIDTH    = 16;
  localparam int Q_FRAC       = 15;
  localparam int PHASE_WIDTH  = 2;

  localparam logic [ENV_WIDTH-1:0]   ENV_ONE   = ENV_WIDTH'(32768);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam int NUM_WIDTH  = COUNT_WIDTH + ENV_WIDTH;
  localparam int PROD_WIDTH = SAMPLE_WIDTH + ENV_WIDTH + 1;
  localparam int DIV_CNT_W  = $clog2(ENV_WIDTH);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COUNT_WIDTH;

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_LEN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_LEN      = 3'd4;

  localparam logic [PHASE_WIDTH-1:0] PHASE_ATTACK  = 2'd0;
  localparam logic [PHASE_WIDTH-1:0] PHASE_DECAY   = 2'd1;
  localparam logic [PHASE_WIDTH-1:0] PHASE_SUSTAIN = 2'd2;
  localparam logic [PHASE_WIDTH-1:0] PHASE_RELEASE = 2'd3;

  localparam logic [COUNT_WIDTH-1:0] RST_ATTACK_LEN    = COUNT_WIDTH'(441);
  localparam logic [COUNT_WIDTH-1:0] RST_DECAY_LEN     = COUNT_WIDTH'(8820);
  localparam logic [LEVEL_WIDTH-1:0] RST_SUSTAIN_LEVEL = LEVEL_WIDTH'(19661);
  localparam logic [COUNT_WIDTH-1:0] RST_RELEASE_LEN   = COUNT_WIDTH'(8820);
  localparam logic [COUNT_WIDTH-1:0] RST_NOTE_LEN      = COUNT_WIDTH'(44100);

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] attack_len;
    logic [COUNT_WIDTH-1:0] decay_len;
    logic [LEVEL_WIDTH-1:0] sustain_level;
    logic [COUNT_WIDTH-1:0] release_len;
    logic [COUNT_WIDTH-1:0] note_len;
  } adsr_cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic [PHASE_WIDTH-1:0]         phase;
    logic                           use_div;
    logic                           invert;
    logic [ENV_WIDTH-1:0]           env_const;
    logic [NUM_WIDTH-1:0]           num;
    logic [COUNT_WIDTH-1:0]         den;
  } adsr_job_t;

endpackage

>>> rtl/core/adsr_front.sv
// ---------------------------------------------------------------------------
// ADSR front end
// Accepts samples, tracks the note index, picks the phase and forms the
// numerator and divisor of the envelope ramp for the back end.
// ---------------------------------------------------------------------------
module adsr_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [adsr_pkg::SAMPLE_WIDTH-1:0] in_sample_in,
  input  logic                                  in_note_start,
  input  adsr_pkg::adsr_cfg_t                   cfg,
  input  logic                                  q_full,
  output logic                                  q_push,
  output adsr_pkg::adsr_job_t                   q_job
);

  typedef enum logic [2:0] {
    F_IDLE  = 3'b001,
    F_CLASS = 3'b010,
    F_PUSH  = 3'b100
  } front_state_t;

  front_state_t state_r, state_nxt;

  logic [adsr_pkg::COUNT_WIDTH-1:0]         index_r, index_nxt;
  logic [adsr_pkg::COUNT_WIDTH-1:0]         cur_r, cur_nxt;
  logic signed [adsr_pkg::SAMPLE_WIDTH-1:0] sample_r, sample_nxt;

  logic [adsr_pkg::PHASE_WIDTH-1:0] phase_r, phase_nxt;
  logic                             use_div_r, use_div_nxt;
  logic                             inv_r, inv_nxt;
  logic [adsr_pkg::ENV_WIDTH-1:0]   env_const_r, env_const_nxt;
  logic [adsr_pkg::COUNT_WIDTH-1:0] mul_a_r, mul_a_nxt;
  logic [adsr_pkg::ENV_WIDTH-1:0]   mul_b_r, mul_b_nxt;
  logic [adsr_pkg::COUNT_WIDTH-1:0] den_r, den_nxt;

  logic                             accept;
  logic [adsr_pkg::COUNT_WIDTH-1:0] idx_new;
  logic [adsr_pkg::ENV_WIDTH-1:0]   sus_lvl;
  logic [adsr_pkg::COUNT_WIDTH:0]   start_sus;
  logic [adsr_pkg::COUNT_WIDTH-1:0] end_sus;
  logic [adsr_pkg::COUNT_WIDTH-1:0] rel_pos;
  logic [adsr_pkg::COUNT_WIDTH-1:0] rel_left;

  assign in_stall = (state_r != F_IDLE);
  assign accept   = in_valid && (state_r == F_IDLE);
  assign idx_new  = in_note_start ? '0 : index_r;

  assign sus_lvl   = (cfg.sustain_level > adsr_pkg::ENV_ONE) ? adsr_pkg::ENV_ONE
                                                             : cfg.sustain_level;
  assign start_sus = {1'b0, cfg.attack_len} + {1'b0, cfg.decay_len};
  assign end_sus   = (cfg.note_len > cfg.release_len) ? (cfg.note_len - cfg.release_len)
                                                      : cfg.note_len;
  assign rel_pos   = cur_r - end_sus;
  assign rel_left  = cfg.release_len - rel_pos;

  always_comb begin
    phase_nxt     = phase_r;
    use_div_nxt   = use_div_r;
    inv_nxt       = inv_r;
    env_const_nxt = env_const_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    den_nxt       = den_r;
    if (state_r == F_CLASS) begin
      use_div_nxt   = 1'b0;
      inv_nxt       = 1'b0;
      env_const_nxt = '0;
      mul_a_nxt     = '0;
      mul_b_nxt     = '0;
      den_nxt       = '0;
      if (cur_r >= cfg.note_len) begin
        phase_nxt = adsr_pkg::PHASE_RELEASE;
      end else if (cur_r < cfg.attack_len) begin
        phase_nxt   = adsr_pkg::PHASE_ATTACK;
        use_div_nxt = 1'b1;
        mul_a_nxt   = cur_r;
        mul_b_nxt   = adsr_pkg::ENV_ONE;
        den_nxt     = cfg.attack_len;
      end else if ({1'b0, cur_r} < start_sus) begin
        phase_nxt   = adsr_pkg::PHASE_DECAY;
        use_div_nxt = 1'b1;
        inv_nxt     = 1'b1;
        mul_a_nxt   = cur_r - cfg.attack_len;
        mul_b_nxt   = adsr_pkg::ENV_ONE - sus_lvl;
        den_nxt     = cfg.decay_len;
      end else if (cur_r < end_sus) begin
        phase_nxt     = adsr_pkg::PHASE_SUSTAIN;
        env_const_nxt = sus_lvl;
      end else begin
        phase_nxt   = adsr_pkg::PHASE_RELEASE;
        use_div_nxt = 1'b1;
        mul_a_nxt   = rel_left;
        mul_b_nxt   = sus_lvl;
        den_nxt     = cfg.release_len;
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    index_nxt  = index_r;
    cur_nxt    = cur_r;
    sample_nxt = sample_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          cur_nxt    = idx_new;
          sample_nxt = in_sample_in;
          index_nxt  = (idx_new != adsr_pkg::COUNT_MAX) ? idx_new + 1'b1 : idx_new;
          state_nxt  = F_CLASS;
        end
      end
      F_CLASS: state_nxt = F_PUSH;
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign q_push          = (state_r == F_PUSH) && !q_full;
  assign q_job.sample    = sample_r;
  assign q_job.phase     = phase_r;
  assign q_job.use_div   = use_div_r;
  assign q_job.invert    = inv_r;
  assign q_job.env_const = env_const_r;
  assign q_job.num       = mul_a_r * mul_b_r;
  assign q_job.den       = den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      index_r <= '0;
    end else begin
      state_r <= state_nxt;
      index_r <= index_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    sample_r    <= sample_nxt;
    phase_r     <= phase_nxt;
    use_div_r   <= use_div_nxt;
    inv_r       <= inv_nxt;
    env_const_r <= env_const_nxt;
    mul_a_r     <= mul_a_nxt;
    mul_b_r     <= mul_b_nxt;
    den_r       <= den_nxt;
  end

endmodule

>>> rtl/core/adsr_queue.sv
// ---------------------------------------------------------------------------
// ADSR job queue
// Short register queue between the classifier and the divider back end.
// ---------------------------------------------------------------------------
module adsr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  adsr_pkg::adsr_job_t push_job,
  output logic                full,
  input  logic                pop,
  output adsr_pkg::adsr_job_t pop_job,
  output logic                empty
);

  adsr_pkg::adsr_job_t mem_r [adsr_pkg::QUEUE_DEPTH];

  logic [adsr_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [adsr_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [adsr_pkg::QCNT_W-1:0] count_r, count_nxt;

  localparam logic [adsr_pkg::QPTR_W-1:0] PTR_LAST = adsr_pkg::QPTR_W'(adsr_pkg::QUEUE_DEPTH - 1);
  localparam logic [adsr_pkg::QCNT_W-1:0] CNT_FULL = adsr_pkg::QCNT_W'(adsr_pkg::QUEUE_DEPTH);

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign pop_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < CNT_FULL || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue read while empty");

endmodule

>>> rtl/core/adsr_back.sv
// ---------------------------------------------------------------------------
// ADSR back end
// Runs the serial envelope divide for ramp jobs, scales the sample and holds
// the result in the output register until it is taken.
// ---------------------------------------------------------------------------
module adsr_back (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  adsr_pkg::adsr_job_t                      q_job,
  input  logic                                     q_empty,
  output logic                                     q_pop,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [adsr_pkg::SAMPLE_WIDTH-1:0] out_sample_out,
  output logic [adsr_pkg::PHASE_WIDTH-1:0]         out_phase
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_DIV  = 4'b0010,
    B_MUL  = 4'b0100,
    B_FIN  = 4'b1000
  } back_state_t;

  localparam logic [adsr_pkg::DIV_CNT_W-1:0] DIV_LAST =
    adsr_pkg::DIV_CNT_W'(adsr_pkg::ENV_WIDTH - 1);
  localparam logic signed [adsr_pkg::PROD_WIDTH-1:0] ROUND_BIAS =
    adsr_pkg::PROD_WIDTH'((1 << adsr_pkg::Q_FRAC) - 1);

  back_state_t state_r, state_nxt;

  logic signed [adsr_pkg::SAMPLE_WIDTH-1:0] sample_r, sample_nxt;
  logic [adsr_pkg::PHASE_WIDTH-1:0]         phase_r, phase_nxt;
  logic                                     use_div_r, use_div_nxt;
  logic                                     inv_r, inv_nxt;
  logic [adsr_pkg::ENV_WIDTH-1:0]           env_const_r, env_const_nxt;
  logic [adsr_pkg::COUNT_WIDTH-1:0]         den_r, den_nxt;
  logic [adsr_pkg::COUNT_WIDTH-1:0]         rem_r, rem_nxt;
  logic [adsr_pkg::ENV_WIDTH-1:0]           lo_r, lo_nxt;
  logic [adsr_pkg::DIV_CNT_W-1:0]           cnt_r, cnt_nxt;
  logic signed [adsr_pkg::PROD_WIDTH-1:0]   prod_r, prod_nxt;

  logic                                     out_valid_r, out_valid_nxt;
  logic signed [adsr_pkg::SAMPLE_WIDTH-1:0] out_sample_r, out_sample_nxt;
  logic [adsr_pkg::PHASE_WIDTH-1:0]         out_phase_r, out_phase_nxt;

  logic [adsr_pkg::COUNT_WIDTH:0]         trial;
  logic [adsr_pkg::COUNT_WIDTH:0]         trial_diff;
  logic                                   trial_ge;
  logic [adsr_pkg::ENV_WIDTH-1:0]         env;
  logic signed [adsr_pkg::ENV_WIDTH:0]    env_s;
  logic signed [adsr_pkg::PROD_WIDTH-1:0] rounded;
  logic signed [adsr_pkg::PROD_WIDTH-1:0] scaled;
  logic                                   out_free;

  assign trial      = {rem_r, lo_r[adsr_pkg::ENV_WIDTH-1]};
  assign trial_diff = trial - {1'b0, den_r};
  assign trial_ge   = (trial >= {1'b0, den_r});

  assign env    = use_div_r ? (inv_r ? adsr_pkg::ENV_ONE - lo_r : lo_r) : env_const_r;
  assign env_s  = $signed({1'b0, env});

  assign rounded = prod_r[adsr_pkg::PROD_WIDTH-1] ? prod_r + ROUND_BIAS : prod_r;
  assign scaled  = rounded >>> adsr_pkg::Q_FRAC;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == B_IDLE) && !q_empty;

  always_comb begin
    state_nxt      = state_r;
    sample_nxt     = sample_r;
    phase_nxt      = phase_r;
    use_div_nxt    = use_div_r;
    inv_nxt        = inv_r;
    env_const_nxt  = env_const_r;
    den_nxt        = den_r;
    rem_nxt        = rem_r;
    lo_nxt         = lo_r;
    cnt_nxt        = cnt_r;
    prod_nxt       = prod_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_sample_nxt = out_sample_r;
    out_phase_nxt  = out_phase_r;
    case (state_r)
      B_IDLE: begin
        if (q_pop) begin
          sample_nxt    = q_job.sample;
          phase_nxt     = q_job.phase;
          use_div_nxt   = q_job.use_div;
          inv_nxt       = q_job.invert;
          env_const_nxt = q_job.env_const;
          den_nxt       = q_job.den;
          rem_nxt       = q_job.num[adsr_pkg::NUM_WIDTH-1:adsr_pkg::ENV_WIDTH];
          lo_nxt        = q_job.num[adsr_pkg::ENV_WIDTH-1:0];
          cnt_nxt       = '0;
          state_nxt     = q_job.use_div ? B_DIV : B_MUL;
        end
      end
      B_DIV: begin
        rem_nxt = trial_ge ? trial_diff[adsr_pkg::COUNT_WIDTH-1:0]
                           : trial[adsr_pkg::COUNT_WIDTH-1:0];
        lo_nxt  = {lo_r[adsr_pkg::ENV_WIDTH-2:0], trial_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        prod_nxt  = sample_r * env_s;
        state_nxt = B_FIN;
      end
      B_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = scaled[adsr_pkg::SAMPLE_WIDTH-1:0];
          out_phase_nxt  = phase_r;
          state_nxt      = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r     <= sample_nxt;
    phase_r      <= phase_nxt;
    use_div_r    <= use_div_nxt;
    inv_r        <= inv_nxt;
    env_const_r  <= env_const_nxt;
    den_r        <= den_nxt;
    rem_r        <= rem_nxt;
    lo_r         <= lo_nxt;
    cnt_r        <= cnt_nxt;
    prod_r       <= prod_nxt;
    out_sample_r <= out_sample_nxt;
    out_phase_r  <= out_phase_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_phase      = out_phase_r;

  a_div_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> use_div_r)
    else $error("divider running on a job without a ramp");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV && cnt_r == DIV_LAST) |=> (state_r == B_MUL))
    else $error("divider did not hand over after the last step");

  a_decay_quot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_MUL && use_div_r && inv_r) |-> (lo_r < adsr_pkg::ENV_ONE))
    else $error("decay quotient out of range");

endmodule

>>> rtl/core/adsr_envelope_shaper_unit.sv
// ---------------------------------------------------------------------------
// ADSR envelope shaper unit
// Scales a stream of Q1.15 note samples by a linear attack, decay, sustain
// and release envelope.
//
// Input channel in_valid / in_stall carries in_sample_in and in_note_start;
// a set note_start restarts the note index for that sample. Each input item
// yields exactly one item on out_valid / out_stall: out_sample_out and the
// phase code out_phase. Configuration is a plain write port (cfg_wr_en,
// cfg_index, cfg_wdata); the user must write it only while the unit is idle,
// as the unit does not enforce this. The front end classifies and queues
// each item before it takes the next. Ramp phases run a 16-step serial
// divider in the back end; sustain and past-end items skip it and go
// straight to the multiply. The divider sets the rate.
// A two-entry queue sits between front and back end; while out_stall is
// high the result is held and the front end keeps accepting until the
// queue fills. Reset (rst_n low, synchronous) empties the pipeline, clears
// the note index and loads the default register values.
// ---------------------------------------------------------------------------
module adsr_envelope_shaper_unit (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [adsr_pkg::SAMPLE_WIDTH-1:0] in_sample_in,
  input  logic                                     in_note_start,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [adsr_pkg::SAMPLE_WIDTH-1:0] out_sample_out,
  output logic [adsr_pkg::PHASE_WIDTH-1:0]         out_phase,
  input  logic                                     cfg_wr_en,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [adsr_pkg::CFG_DATA_W-1:0]          cfg_wdata
);

  adsr_pkg::adsr_cfg_t cfg_r, cfg_nxt;
  adsr_pkg::adsr_job_t push_job, pop_job;
  logic                q_push, q_pop, q_full, q_empty;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        adsr_pkg::REG_ATTACK_LEN:    cfg_nxt.attack_len    = cfg_wdata;
        adsr_pkg::REG_DECAY_LEN:     cfg_nxt.decay_len     = cfg_wdata;
        adsr_pkg::REG_SUSTAIN_LEVEL:
          cfg_nxt.sustain_level = cfg_wdata[adsr_pkg::LEVEL_WIDTH-1:0];
        adsr_pkg::REG_RELEASE_LEN:   cfg_nxt.release_len   = cfg_wdata;
        adsr_pkg::REG_NOTE_LEN:      cfg_nxt.note_len      = cfg_wdata;
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_len    <= adsr_pkg::RST_ATTACK_LEN;
      cfg_r.decay_len     <= adsr_pkg::RST_DECAY_LEN;
      cfg_r.sustain_level <= adsr_pkg::RST_SUSTAIN_LEVEL;
      cfg_r.release_len   <= adsr_pkg::RST_RELEASE_LEN;
      cfg_r.note_len      <= adsr_pkg::RST_NOTE_LEN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  adsr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_in  (in_sample_in),
    .in_note_start (in_note_start),
    .cfg           (cfg_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (push_job)
  );

  adsr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  adsr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_job          (pop_job),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_phase      (out_phase)
  );

endmodule

>>> verif/tb_adsr_envelope_shaper_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the ADSR envelope shaper unit
// Sends note samples with start flags through the valid/stall input channel,
// predicts each shaped sample and its phase code from a local copy of the
// envelope registers and the note index, and checks every result in order.
// The envelope registers are reloaded between runs of items while the unit
// is idle: directed settings first, then random ones. The sender and the
// receiver idle at random in two mixes, then run without gaps. One long
// receiver hold-off backs the unit up into its input.
// ---------------------------------------------------------------------------
module tb_adsr_envelope_shaper_unit;
  import adsr_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 7;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_LEN = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_SETTINGS = 12;
  localparam int ITEMS_PER_SETTING = 58;
  localparam longint Q_ONE = longint'(1) << Q_FRAC;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           start;
  } note_item_t;

  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic [PHASE_WIDTH-1:0]         phase;
  } shaped_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_WIDTH-1:0] in_sample_in = '0;
  logic in_note_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_out;
  logic [PHASE_WIDTH-1:0] out_phase;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [COUNT_WIDTH-1:0] env_attack, env_decay, env_release, env_note;
  logic [LEVEL_WIDTH-1:0] env_sustain;
  logic [COUNT_WIDTH-1:0] note_pos;

  note_item_t pending_samples[$];
  shaped_t    shaped_due[$];

  logic in_taken = 1'b0;
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int hold_asked = 0;
  int hold_done = 0;
  int hold_left = 0;
  int idle_run = 0;
  int queued_total = 0;
  int results_total = 0;
  int checked_cnt = 0;
  int settings_cnt = 0;
  int err_count = 0;
  int phase_seen[4] = '{0, 0, 0, 0};

  adsr_envelope_shaper_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample_in(in_sample_in),
    .in_note_start(in_note_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sample_out(out_sample_out),
    .out_phase(out_phase),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 40) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic shaped_t shape_sample(input logic signed [SAMPLE_WIDTH-1:0] x,
                                           input logic [COUNT_WIDTH-1:0] pos);
    longint a, d, r, n, s, i, knee, tail, env, prod;
    shaped_t res;
    a = env_attack;
    d = env_decay;
    r = env_release;
    n = env_note;
    s = (env_sustain > ENV_ONE) ? Q_ONE : longint'(env_sustain);
    i = pos;
    knee = a + d;
    tail = (n > r) ? n - r : n;
    if (i >= n) begin
      env = 0;
      res.phase = PHASE_RELEASE;
    end else if (i < a) begin
      env = (i * Q_ONE) / a;
      res.phase = PHASE_ATTACK;
    end else if (i < knee) begin
      env = Q_ONE - ((i - a) * (Q_ONE - s)) / d;
      res.phase = PHASE_DECAY;
    end else if (i < tail) begin
      env = s;
      res.phase = PHASE_SUSTAIN;
    end else begin
      env = (s * (r - (i - tail))) / r;
      res.phase = PHASE_RELEASE;
    end
    prod = (longint'(x) * env) / Q_ONE;
    res.sample = prod[SAMPLE_WIDTH-1:0];
    return res;
  endfunction

  always @(posedge clk) begin : track_and_check
    logic [COUNT_WIDTH-1:0] pos;
    shaped_t want;
    logic any_fire;
    logic took;
    any_fire = 1'b0;
    took = 1'b0;
    if (!rst_n) begin
      env_attack <= RST_ATTACK_LEN;
      env_decay <= RST_DECAY_LEN;
      env_sustain <= RST_SUSTAIN_LEVEL;
      env_release <= RST_RELEASE_LEN;
      env_note <= RST_NOTE_LEN;
      note_pos <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ATTACK_LEN: env_attack <= cfg_wdata;
          REG_DECAY_LEN: env_decay <= cfg_wdata;
          REG_SUSTAIN_LEVEL: env_sustain <= cfg_wdata[LEVEL_WIDTH-1:0];
          REG_RELEASE_LEN: env_release <= cfg_wdata;
          REG_NOTE_LEN: env_note <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        pos = in_note_start ? '0 : note_pos;
        shaped_due.push_back(shape_sample(in_sample_in, pos));
        note_pos <= (pos < COUNT_MAX) ? pos + 1'b1 : pos;
        took = 1'b1;
        any_fire = 1'b1;
      end
      if (out_valid && !out_stall) begin
        any_fire = 1'b1;
        results_total <= results_total + 1;
        if (shaped_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result sample %0d phase %0d",
                                    out_sample_out, out_phase));
        end else begin
          want = shaped_due.pop_front();
          checked_cnt <= checked_cnt + 1;
          phase_seen[want.phase] <= phase_seen[want.phase] + 1;
          if (out_sample_out !== want.sample)
            report_mismatch($sformatf("sample_out %0d, expected %0d (phase %0d)",
                                      out_sample_out, want.sample, want.phase));
          if (out_phase !== want.phase)
            report_mismatch($sformatf("phase %0d, expected %0d", out_phase, want.phase));
        end
      end
    end
    in_taken <= took;
    idle_run <= any_fire ? 0 : idle_run + 1;
  end

  always @(negedge clk) begin : drive_samples
    note_item_t nxt;
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_samples.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        nxt = pending_samples.pop_front();
        in_valid <= 1'b1;
        in_sample_in <= nxt.sample;
        in_note_start <= nxt.start;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_stall
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_asked) begin
      hold_done <= hold_asked;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_gap_pct);
    end
  end

  initial begin : watchdog
    while (idle_run < WATCHDOG_LIMIT) @(posedge clk);
    $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic apply_setting(input logic [COUNT_WIDTH-1:0] a, d,
                               input logic [LEVEL_WIDTH-1:0] s,
                               input logic [COUNT_WIDTH-1:0] r, n,
                               input bit stray);
    put_reg(REG_ATTACK_LEN, a);
    put_reg(REG_DECAY_LEN, d);
    put_reg(REG_SUSTAIN_LEVEL, {(CFG_DATA_W - LEVEL_WIDTH)'($urandom), s});
    put_reg(REG_RELEASE_LEN, r);
    put_reg(REG_NOTE_LEN, n);
    if (stray)
      put_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
              CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings_cnt++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (results_total < queued_total);
  endtask

  task automatic push_sample(input logic signed [SAMPLE_WIDTH-1:0] x, input logic start);
    note_item_t it;
    it.sample = x;
    it.start = start;
    pending_samples.push_back(it);
    queued_total++;
  endtask

  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return -16'sd1;
      3: return '0;
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] pick_len(input int unsigned span);
    case ($urandom_range(0, 19))
      0: return COUNT_MAX;
      1: return COUNT_WIDTH'($urandom);
      2: return '0;
      default: return COUNT_WIDTH'($urandom_range(0, span));
    endcase
  endfunction

  task automatic queue_note(input int len);
    for (int k = 0; k < len; k++)
      push_sample(pick_sample(),
                  (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0));
  endtask

  task automatic random_setting(output logic [COUNT_WIDTH-1:0] n);
    logic [COUNT_WIDTH-1:0] a, d, r;
    logic [LEVEL_WIDTH-1:0] s;
    a = pick_len(12);
    d = pick_len(12);
    r = pick_len(16);
    n = pick_len(60);
    case ($urandom_range(0, 4))
      0: s = '0;
      1: s = ENV_ONE;
      2: s = LEVEL_WIDTH'($urandom_range(0, 32768));
      default: s = LEVEL_WIDTH'($urandom);
    endcase
    apply_setting(a, d, s, r, n, $urandom_range(0, 2) == 0);
  endtask

  initial begin : stimulus
    logic signed [SAMPLE_WIDTH-1:0] ramp_samples[14];
    logic [COUNT_WIDTH-1:0] n;
    int added, len, cap;
    ramp_samples = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, -16'sd1, 16'sd1,
                     16'sh7fff, 16'sh8000, 16'sd12345, -16'sd12345, 16'sh7fff,
                     16'sh8000, 16'sh7fff, -16'sd1};
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values, start of a note
    push_sample(16'sh7fff, 1'b1);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    wait_drained();

    // every phase in turn, then past the note end
    apply_setting(24'd2, 24'd3, 16'd20000, 24'd4, 24'd12, 1'b1);
    foreach (ramp_samples[k]) push_sample(ramp_samples[k], k == 0);
    wait_drained();

    // short note with zero attack and decay, sustain above one
    apply_setting(24'd0, 24'd0, 16'hffff, 24'd20, 24'd10, 1'b0);
    push_sample(16'sh8000, 1'b1);
    push_sample(16'sh7fff, 1'b0);
    push_sample(-16'sd1, 1'b0);
    wait_drained();

    // zero note length
    apply_setting(24'd5, 24'd5, ENV_ONE, 24'd0, 24'd0, 1'b0);
    push_sample(16'sh7fff, 1'b1);
    push_sample(16'sh8000, 1'b0);
    wait_drained();

    // largest lengths
    apply_setting(COUNT_MAX, COUNT_MAX, ENV_ONE, COUNT_MAX, COUNT_MAX, 1'b1);
    push_sample(16'sh7fff, 1'b1);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    wait_drained();

    for (int ph = 0; ph < RANDOM_SETTINGS; ph++) begin
      case (ph / 4)
        0: begin send_gap_pct = 25; recv_gap_pct = 62; end
        1: begin send_gap_pct = 62; recv_gap_pct = 25; end
        default: begin send_gap_pct = 0; recv_gap_pct = 0; end
      endcase
      random_setting(n);
      cap = (n > 70) ? 78 : int'(n) + 8;
      added = 0;
      while (added < ITEMS_PER_SETTING) begin
        len = $urandom_range(1, cap);
        queue_note(len);
        added += len;
      end
      // back the unit up into its input
      if (ph == 9) hold_asked++;
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (shaped_due.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", shaped_due.size()));
    $display("checked %0d shaped samples over %0d envelope settings",
             checked_cnt, settings_cnt);
    $display("phases: attack %0d, decay %0d, sustain %0d, release or past end %0d",
             phase_seen[0], phase_seen[1], phase_seen[2], phase_seen[3]);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
